FILE: src/lom_pkg.sv
package lom_pkg;

   localparam int BOOK_DEPTH_DEF = 64;
   localparam int PRICE_BITS_DEF = 30;
   localparam int QTY_BITS_DEF   = 30;
   localparam int TRADED_BITS    = 30;
   localparam int BACKLOG_BITS   = 37;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_TRADE,
      ST_REST,
      ST_DONE
   } state_type;

endpackage

FILE: src/limit_order_matcher_unit.sv
// Channel | Direction | Ports
// req     | in        | req_valid, req_stall, req_limit_price, req_quantity, req_side
// rsp     | out       | rsp_valid, rsp_stall, rsp_traded_qty, rsp_backlog_total, rsp_book_full
// One order at a time: the order is accepted, then each match scans the opposite book's
// n entries through the RAM read port, one entry a cycle (each later match first reads
// entry 0 again after the write), then the remainder is rested and the result presented.
// An order with nothing to scan goes straight from acceptance to resting.
// Synchronous reset clears the counts and total; book RAMs need no clearing.
// A stalled result holds; req_stall stays high until the result is transferred.
module limit_order_matcher_unit #(
   parameter int BOOK_DEPTH = lom_pkg::BOOK_DEPTH_DEF,
   parameter int PRICE_BITS = lom_pkg::PRICE_BITS_DEF,
   parameter int QTY_BITS   = lom_pkg::QTY_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [PRICE_BITS-1:0]           req_limit_price,
   input  logic [QTY_BITS-1:0]             req_quantity,
   input  logic                            req_side,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lom_pkg::TRADED_BITS-1:0] rsp_traded_qty,
   output logic [lom_pkg::BACKLOG_BITS-1:0] rsp_backlog_total,
   output logic                            rsp_book_full
);

   localparam int AW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
   localparam int CW = $clog2(BOOK_DEPTH + 1);
   localparam int EW = PRICE_BITS + QTY_BITS;
   localparam int BW = lom_pkg::BACKLOG_BITS;

   lom_pkg::state_type state_ff, state_in;

   logic [CW-1:0] cnt_ff [2];
   logic [CW-1:0] cnt_in [2];
   logic [BW-1:0] total_ff, total_in;
   logic [PRICE_BITS-1:0] price_ff, price_in;
   logic [QTY_BITS-1:0]   remain_ff, remain_in;
   logic                  side_ff, side_in;
   logic [QTY_BITS-1:0]   traded_ff, traded_in;
   logic                  full_ff, full_in;
   logic [CW-1:0]         idx_ff, idx_in;   // next read address
   logic [AW-1:0]         best_ff, best_in;
   logic [PRICE_BITS-1:0] bp_ff, bp_in;
   logic [QTY_BITS-1:0]   bq_ff, bq_in;
   logic [AW-1:0]         rdi_ff, rdi_in;   // address of data now on rd_data
   logic                  first_ff, first_in;
   logic [lom_pkg::TRADED_BITS-1:0] o_trd_ff, o_trd_in;
   logic [BW-1:0]         o_tot_ff, o_tot_in;
   logic                  o_full_ff, o_full_in;

   // RAM ports
   logic          we [2];
   logic [AW-1:0] wa [2];
   logic [EW-1:0] wd [2];
   logic [AW-1:0] ra;
   logic [EW-1:0] rd [2];

   genvar g;
   generate
      for (g = 0; g < 2; g++) begin : g_book
         lom_ram #(.WIDTH(EW), .DEPTH(BOOK_DEPTH)) u_ram (
            .clock  (clock),
            .wr_en  (we[g]),
            .wr_addr(wa[g]),
            .wr_data(wd[g]),
            .rd_addr(ra),
            .rd_data(rd[g])
         );
      end
   endgenerate

   logic          opp;
   logic [EW-1:0] rdat;
   logic [PRICE_BITS-1:0] rp;
   logic [QTY_BITS-1:0]   rq;
   logic          better, crosses;
   logic [QTY_BITS-1:0] m;
   logic [CW-1:0] ocnt;

   assign opp  = ~side_ff;      // buy book index 0, sell book index 1
   assign rdat = rd[opp];
   assign rp   = rdat[EW-1:QTY_BITS];
   assign rq   = rdat[QTY_BITS-1:0];
   assign ocnt = cnt_ff[opp];

   always_comb begin
      if (rp != bp_ff) begin
         better = side_ff ? (rp > bp_ff) : (rp < bp_ff);
      end else begin
         better = rq < bq_ff;
      end
      crosses = side_ff ? (bp_ff >= price_ff) : (bp_ff <= price_ff);
      m = (bq_ff < remain_ff) ? bq_ff : remain_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= lom_pkg::ST_IDLE;
         cnt_ff[0] <= '0;
         cnt_ff[1] <= '0;
         total_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff[0] <= cnt_in[0];
         cnt_ff[1] <= cnt_in[1];
         total_ff  <= total_in;
      end
      price_ff <= price_in;  remain_ff <= remain_in; side_ff <= side_in;
      traded_ff <= traded_in; full_ff <= full_in;    idx_ff <= idx_in;
      best_ff <= best_in;    bp_ff <= bp_in;         bq_ff <= bq_in;
      rdi_ff <= rdi_in;      first_ff <= first_in;
      o_trd_ff <= o_trd_in;  o_tot_ff <= o_tot_in;   o_full_ff <= o_full_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in[0] = cnt_ff[0]; cnt_in[1] = cnt_ff[1];
      total_in = total_ff;
      price_in = price_ff; remain_in = remain_ff; side_in = side_ff;
      traded_in = traded_ff; full_in = full_ff; idx_in = idx_ff;
      best_in = best_ff; bp_in = bp_ff; bq_in = bq_ff;
      rdi_in = rdi_ff; first_in = first_ff;
      o_trd_in = o_trd_ff; o_tot_in = o_tot_ff; o_full_in = o_full_ff;
      we[0] = 1'b0; we[1] = 1'b0;
      wa[0] = best_ff; wa[1] = best_ff;
      wd[0] = '0; wd[1] = '0;
      ra = idx_ff[AW-1:0];
      req_stall = 1'b1;
      rsp_valid = 1'b0;

      case (state_ff)
         lom_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            ra = '0;
            if (req_valid) begin
               price_in  = req_limit_price;
               remain_in = req_quantity;
               side_in   = req_side;
               traded_in = '0;
               full_in   = 1'b0;
               state_in  = lom_pkg::ST_REST;
               if (req_quantity != '0 && cnt_ff[~req_side] != '0) begin
                  // read of entry 0 issued now
                  idx_in   = CW'(1);
                  rdi_in   = '0;
                  first_in = 1'b1;
                  state_in = lom_pkg::ST_SCAN;
               end
            end
         end
         lom_pkg::ST_SCAN: begin
            // fold entry rdi_ff, issue next read
            if (first_ff || better) begin
               best_in = rdi_ff;
               bp_in   = rp;
               bq_in   = rq;
            end
            first_in = 1'b0;
            rdi_in   = idx_ff[AW-1:0];
            if (idx_ff >= ocnt) begin
               // last read (of count-1) was folded now
               ra = AW'(ocnt - CW'(1));
               state_in = lom_pkg::ST_TRADE;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         lom_pkg::ST_TRADE: begin
            // rd holds entry count-1 for swap-remove
            if (!crosses) begin
               state_in = lom_pkg::ST_REST;
            end else begin
               remain_in = remain_ff - m;
               traded_in = traded_ff + m;
               total_in  = total_ff - BW'(m);
               we[opp] = 1'b1;
               if (bq_ff == m) begin
                  wd[opp] = rdat;
                  cnt_in[opp] = ocnt - CW'(1);
               end else begin
                  wd[opp] = {bp_ff, bq_ff - m};
               end
               if (remain_ff != m && !(bq_ff == m && ocnt == CW'(1))) begin
                  ra       = '0;
                  idx_in   = CW'(1);
                  rdi_in   = '0;
                  first_in = 1'b1;
                  state_in = lom_pkg::ST_LAST;
               end else begin
                  state_in = lom_pkg::ST_REST;
               end
            end
         end
         lom_pkg::ST_LAST: begin
            // write of previous cycle may hit entry 0; reissue read
            ra = '0;
            state_in = lom_pkg::ST_SCAN;
         end
         lom_pkg::ST_REST: begin
            if (remain_ff != '0) begin
               if (cnt_ff[side_ff] >= CW'(BOOK_DEPTH)) begin
                  full_in = 1'b1;
               end else begin
                  we[side_ff] = 1'b1;
                  wa[side_ff] = cnt_ff[side_ff][AW-1:0];
                  wd[side_ff] = {price_ff, remain_ff};
                  cnt_in[side_ff] = cnt_ff[side_ff] + CW'(1);
                  total_in = total_ff + BW'(remain_ff);
               end
            end
            state_in = lom_pkg::ST_DONE;
         end
         lom_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = lom_pkg::ST_IDLE;
            end
         end
         default: state_in = lom_pkg::ST_IDLE;
      endcase

      if (state_ff == lom_pkg::ST_REST) begin
         o_trd_in  = lom_pkg::TRADED_BITS'(traded_ff);
         o_tot_in  = total_in;
         o_full_in = full_in;
      end
   end

   assign rsp_traded_qty    = o_trd_ff;
   assign rsp_backlog_total = o_tot_ff;
   assign rsp_book_full     = o_full_ff;

endmodule

FILE: src/lom_ram.sv
module lom_ram #(
   parameter int WIDTH = 60,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: dv/limit_order_matcher_unit_tb.sv
`timescale 1ns / 1ps

module limit_order_matcher_unit_tb;

   localparam int DEPTH      = lom_pkg::BOOK_DEPTH_DEF;
   localparam int PW         = lom_pkg::PRICE_BITS_DEF;
   localparam int QW         = lom_pkg::QTY_BITS_DEF;
   localparam int TW         = lom_pkg::TRADED_BITS;
   localparam int BW         = lom_pkg::BACKLOG_BITS;
   localparam bit SIDE_BUY   = 1'b0;
   localparam bit SIDE_SELL  = 1'b1;
   localparam int NUM_ORDERS = 1650;
   localparam int IDLE_LIMIT = 60000;
   localparam int DRAIN_WAIT = 300;

   typedef struct {
      bit [TW-1:0] traded;
      bit [BW-1:0] backlog;
      bit          full;
   } fill_type;

   class match_board;
      bit [PW-1:0] buy_px[DEPTH];
      bit [QW-1:0] buy_qt[DEPTH];
      bit [PW-1:0] sell_px[DEPTH];
      bit [QW-1:0] sell_qt[DEPTH];
      int          n_buy;
      int          n_sell;
      bit [BW-1:0] resting;
      fill_type    fills_due[$];
      int          errors;

      function int pending();
         return fills_due.size();
      endfunction

      task report(string msg);
         $display("mismatch @%0t: %s", $realtime, msg);
         errors++;
      endtask

      // Compute the fill for one accepted order and update both books.
      function void note_order(bit [PW-1:0] price, bit [QW-1:0] qty, bit side);
         bit [QW-1:0] left;
         bit [QW-1:0] m;
         bit [TW-1:0] traded;
         bit          full;
         bit          better;
         int          k;
         bit [PW-1:0] p;
         fill_type    f;
         left   = qty;
         traded = '0;
         full   = 1'b0;
         while (left > 0 && (side == SIDE_SELL ? n_buy : n_sell) > 0) begin
            k = 0;
            if (side == SIDE_SELL) begin
               for (int i = 1; i < n_buy; i++) begin
                  if (buy_px[i] != buy_px[k]) better = buy_px[i] > buy_px[k];
                  else better = buy_qt[i] < buy_qt[k];
                  if (better) k = i;
               end
               p = buy_px[k];
               if (p < price) break;
               m = (buy_qt[k] < left) ? buy_qt[k] : left;
               buy_qt[k] -= m;
               if (buy_qt[k] == 0) begin
                  n_buy--;
                  buy_px[k] = buy_px[n_buy];
                  buy_qt[k] = buy_qt[n_buy];
               end
            end else begin
               for (int i = 1; i < n_sell; i++) begin
                  if (sell_px[i] != sell_px[k]) better = sell_px[i] < sell_px[k];
                  else better = sell_qt[i] < sell_qt[k];
                  if (better) k = i;
               end
               p = sell_px[k];
               if (p > price) break;
               m = (sell_qt[k] < left) ? sell_qt[k] : left;
               sell_qt[k] -= m;
               if (sell_qt[k] == 0) begin
                  n_sell--;
                  sell_px[k] = sell_px[n_sell];
                  sell_qt[k] = sell_qt[n_sell];
               end
            end
            left    -= m;
            traded  += TW'(m);
            resting -= BW'(m);
         end
         if (left > 0) begin
            if (side == SIDE_SELL) begin
               if (n_sell >= DEPTH) full = 1'b1;
               else begin
                  sell_px[n_sell] = price;
                  sell_qt[n_sell] = left;
                  n_sell++;
                  resting += BW'(left);
               end
            end else begin
               if (n_buy >= DEPTH) full = 1'b1;
               else begin
                  buy_px[n_buy] = price;
                  buy_qt[n_buy] = left;
                  n_buy++;
                  resting += BW'(left);
               end
            end
         end
         f.traded  = traded;
         f.backlog = resting;
         f.full    = full;
         fills_due.push_back(f);
      endfunction

      task check_fill(bit [TW-1:0] traded, bit [BW-1:0] backlog, bit full);
         fill_type f;
         if (fills_due.size() == 0) begin
            report("fill with no order outstanding");
            return;
         end
         f = fills_due.pop_front();
         if (traded != f.traded)
            report($sformatf("traded_qty %0d, want %0d", traded, f.traded));
         if (backlog != f.backlog)
            report($sformatf("backlog_total %0d, want %0d", backlog, f.backlog));
         if (full != f.full)
            report($sformatf("book_full %0b, want %0b", full, f.full));
      endtask
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [PW-1:0] req_limit_price = '0;
   logic [QW-1:0] req_quantity = '0;
   logic          req_side = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [TW-1:0] rsp_traded_qty;
   logic [BW-1:0] rsp_backlog_total;
   logic          rsp_book_full;

   match_board board = new();
   int  sent;
   int  idle_cycles;
   int  stall_left;
   bit  no_idle;

   limit_order_matcher_unit uut (.*);

   always #5 clock = ~clock;

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Keep valid high across back-to-back orders; drop it only for a gap.
   task send_order(bit [PW-1:0] price, bit [QW-1:0] qty, bit side);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_limit_price <= price;
      req_quantity    <= qty;
      req_side        <= side;
      do @(posedge clock); while (req_stall);
      board.note_order(price, qty, side);
      sent++;
   endtask

   // Hold until every expected fill has been checked.
   task drain();
      while (board.pending() != 0) @(posedge clock);
   endtask

   function bit [QW-1:0] rand_qty();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return QW'($urandom_range(1, 100));
      if (r < 9) return QW'($urandom_range(1, 100000));
      return QW'(($urandom() & ((1 << QW) - 1)) | 1);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("limit_order_matcher_unit_tb NOT OK");
            $finish;
         end
         if (rsp_valid && !rsp_stall)
            board.check_fill(rsp_traded_qty, rsp_backlog_total, rsp_book_full);
         // hold stall for a random stretch, mostly short
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      bit [PW-1:0] base;
      bit [PW-1:0] pmax;
      bit [QW-1:0] qmax;
      int          mode;
      int          n;
      bit          s;
      pmax = '1;
      qmax = '1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // equal prices: smaller quantity first, then lower slot
      send_order(100, 10, SIDE_BUY);
      send_order(100, 5, SIDE_BUY);
      send_order(100, 5, SIDE_BUY);
      send_order(90, 7, SIDE_SELL);
      send_order(95, 20, SIDE_SELL);
      send_order(pmax, 1, SIDE_SELL);
      send_order(0, qmax, SIDE_BUY);
      send_order(0, qmax, SIDE_SELL);
      send_order(pmax, qmax, SIDE_BUY);
      send_order(50, 0, SIDE_SELL);
      send_order(50, 0, SIDE_BUY);
      send_order(pmax, 1, SIDE_BUY);
      send_order(0, 1, SIDE_SELL);
      send_order(200, 3, SIDE_SELL);
      send_order(199, 3, SIDE_BUY);
      send_order(200, 1, SIDE_BUY);

      // let the outstanding fills drain before random traffic
      req_valid <= 1'b0;
      drain();
      @(posedge clock);

      while (sent < NUM_ORDERS) begin
         mode    = $urandom_range(0, 9);
         no_idle = ($urandom_range(0, 5) == 0);
         base    = ($urandom_range(0, 3) == 0) ? PW'($urandom())
                                               : PW'($urandom_range(1000, 2000));
         if (mode <= 5) begin
            for (int i = 0; i < 20; i++)
               send_order(PW'(base + $urandom_range(0, 15)), rand_qty(),
                          1'($urandom_range(0, 1)));
         end else if (mode <= 7) begin
            // one-sided burst that can fill a book
            s = 1'($urandom_range(0, 1));
            n = $urandom_range(30, 75);
            for (int i = 0; i < n; i++)
               send_order(PW'(base + $urandom_range(0, 31)), rand_qty(), s);
         end else if (mode == 8) begin
            s = 1'($urandom_range(0, 1));
            send_order(s == SIDE_SELL ? '0 : pmax, qmax, s);
         end else begin
            for (int i = 0; i < 10; i++)
               send_order(PW'($urandom()), QW'($urandom()), 1'($urandom_range(0, 1)));
         end
         if ($urandom_range(0, 19) == 0) begin
            req_valid <= 1'b0;
            drain();
            @(posedge clock);
         end
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;
      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("limit_order_matcher_unit_tb OK");
      else
         $display("limit_order_matcher_unit_tb NOT OK");
      $finish;
   end

endmodule
